>>> src/rtp_h264_depacketizer_defines.svh
// Assertion macros shared by the checker of the RTP H.264 depacketizer.
// Depends on clk and rst being visible where a macro is used.
`ifndef RTP_H264_DEPACKETIZER_DEFINES_SVH
`define RTP_H264_DEPACKETIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define RHD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rhd assertion failed: same-cycle check");

// Next-cycle implication, sampled on clk, off while in reset.
`define RHD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rhd assertion failed: next-cycle check");

`endif

>>> src/rhd_pkg.sv
// Package of the RTP H.264 depacketizer: constants, register indexes and the
// queue entry type. Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package rhd_pkg;

  // Stream framing
  localparam logic [7:0]  DOLLAR          = 8'h24;
  localparam logic [15:0] RTP_HDR_LEN     = 16'd12;
  localparam logic [15:0] MIN_PKT_LEN     = 16'd13;
  localparam logic [15:0] MIN_FUA_PKT_LEN = 16'd14;
  localparam logic [15:0] IDX_MARKER      = 16'd1;
  localparam logic [15:0] IDX_NAL_HDR     = 16'd12;
  localparam logic [15:0] IDX_FU_HDR      = 16'd13;
  localparam logic [4:0]  NAL_SINGLE_MIN  = 5'd1;
  localparam logic [4:0]  NAL_SINGLE_MAX  = 5'd23;
  localparam logic [4:0]  NAL_FU_A        = 5'd28;

  // Frame buffer capacity clamp
  localparam logic [20:0] CAP_LIMIT = 21'd1048576;

  // Configuration registers
  localparam int          CFG_ADDR_W   = 2;
  localparam int          CFG_DATA_W   = 21;
  localparam logic [1:0]  CFG_FRAME_CAPACITY = 2'd0;
  localparam logic [1:0]  CFG_VIDEO_CHANNEL  = 2'd1;
  localparam logic [1:0]  CFG_MAX_PKT_LEN    = 2'd2;
  localparam logic [20:0] RST_FRAME_CAPACITY = 21'd262144;
  localparam logic [7:0]  RST_VIDEO_CHANNEL  = 8'd0;
  localparam logic [15:0] RST_MAX_PKT_LEN    = 16'd1500;

  // Result sequencing
  localparam logic [2:0] START_CODE_LEN = 3'd5;
  localparam logic [2:0] SC_ONE_POS     = 3'd3;
  localparam logic [2:0] SC_HDR_POS     = 3'd4;

  // Output bus layout
  localparam int FILL_W   = 20;
  localparam int M_DATA_W = 32;

  // Operation queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // One queued operation: what a single input byte asks the back end to emit.
  typedef struct packed {
    logic              sc;     // start code plus NAL header byte in val
    logic              dat;    // one payload byte in val
    logic              fin;    // frame end with count
    logic [7:0]        val;
    logic [FILL_W-1:0] count;
  } op_t;

endpackage

>>> src/rhd_front.sv
// Front end of the RTP H.264 depacketizer: holds the configuration registers,
// parses the interleaved stream and turns each byte that has results into a
// queued operation. Depends on rhd_pkg.
`timescale 1ns / 1ps

module rhd_front
  import rhd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  take,
  input  logic [7:0]            in_byte,
  output logic                  push,
  output op_t                   push_op
);

  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_CHAN   = 3'd1;
  localparam logic [2:0] PH_LEN_HI = 3'd2;
  localparam logic [2:0] PH_LEN_LO = 3'd3;
  localparam logic [2:0] PH_BODY   = 3'd4;
  localparam logic [2:0] PH_SKIP   = 3'd5;

  localparam logic [1:0] PK_NONE   = 2'd0;
  localparam logic [1:0] PK_SINGLE = 2'd1;
  localparam logic [1:0] PK_FUA    = 2'd2;

  logic [20:0]       frame_capacity;
  logic [7:0]        video_channel;
  logic [15:0]       max_packet_len;

  logic [2:0]        phase, phase_next;
  logic [7:0]        channel_id, channel_id_next;
  logic [15:0]       packet_length, packet_length_next;
  logic [15:0]       byte_index, byte_index_next;
  logic              marker_flag, marker_flag_next;
  logic [7:0]        nal_header, nal_header_next;
  logic [1:0]        payload_kind, payload_kind_next;
  logic              will_store, will_store_next;
  logic [FILL_W-1:0] frame_fill, frame_fill_next;

  logic [15:0]       idx_inc;
  logic [15:0]       len_full;
  logic [15:0]       nal_len;
  logic [16:0]       extra;
  logic [20:0]       cap_eff;
  logic              fits_ok;
  logic [FILL_W-1:0] fill_mid;
  logic              pkt_ok;
  op_t               op;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_capacity <= RST_FRAME_CAPACITY;
      video_channel  <= RST_VIDEO_CHANNEL;
      max_packet_len <= RST_MAX_PKT_LEN;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_FRAME_CAPACITY: frame_capacity <= cfg_wdata;
        CFG_VIDEO_CHANNEL:  video_channel  <= cfg_wdata[7:0];
        CFG_MAX_PKT_LEN:    max_packet_len <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign idx_inc  = byte_index + 16'd1;
  assign len_full = {packet_length[15:8], in_byte};
  assign nal_len  = packet_length - RTP_HDR_LEN;
  assign cap_eff  = (frame_capacity > CAP_LIMIT) ? CAP_LIMIT : frame_capacity;

  // One fit check serves all three cases; the byte position and the FU start bit pick the size.
  always_comb begin
    if (byte_index == IDX_NAL_HDR) begin
      extra = {1'b0, nal_len} + 17'd4;
    end else if (in_byte[7]) begin
      extra = {1'b0, nal_len} + 17'd3;
    end else begin
      extra = {1'b0, nal_len} - 17'd2;
    end
  end

  assign fits_ok = ({1'b0, frame_fill} + {4'b0, extra}) < cap_eff;

  always_comb begin
    phase_next         = phase;
    channel_id_next    = channel_id;
    packet_length_next = packet_length;
    byte_index_next    = byte_index;
    marker_flag_next   = marker_flag;
    nal_header_next    = nal_header;
    payload_kind_next  = payload_kind;
    will_store_next    = will_store;
    frame_fill_next    = frame_fill;
    fill_mid           = frame_fill;
    pkt_ok             = 1'b0;
    op                 = '0;

    unique case (phase)
      PH_HUNT: begin
        if (in_byte == DOLLAR) begin
          phase_next = PH_CHAN;
        end
      end
      PH_CHAN: begin
        channel_id_next = in_byte;
        phase_next      = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        packet_length_next = {in_byte, 8'h00};
        phase_next         = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        packet_length_next = len_full;
        byte_index_next    = '0;
        marker_flag_next   = 1'b0;
        payload_kind_next  = PK_NONE;
        will_store_next    = 1'b0;
        if (len_full == 16'd0) begin
          phase_next = PH_HUNT;
        end else if (len_full > max_packet_len || channel_id != video_channel ||
                     len_full < MIN_PKT_LEN) begin
          phase_next = PH_SKIP;
        end else begin
          phase_next = PH_BODY;
        end
      end
      PH_SKIP: begin
        byte_index_next = idx_inc;
        if (idx_inc >= packet_length) begin
          phase_next = PH_HUNT;
        end
      end
      PH_BODY: begin
        if (byte_index == IDX_MARKER) begin
          marker_flag_next = in_byte[7];
        end
        if (byte_index == IDX_NAL_HDR) begin
          nal_header_next = in_byte;
          if (in_byte[4:0] >= NAL_SINGLE_MIN && in_byte[4:0] <= NAL_SINGLE_MAX) begin
            payload_kind_next = PK_SINGLE;
            will_store_next   = fits_ok;
            op.sc             = fits_ok;
            op.val            = in_byte;
          end else if (in_byte[4:0] == NAL_FU_A) begin
            payload_kind_next = PK_FUA;
            will_store_next   = 1'b0;
          end else begin
            payload_kind_next = PK_NONE;
            will_store_next   = 1'b0;
          end
        end else if (byte_index == IDX_FU_HDR && payload_kind == PK_FUA) begin
          // Rebuild the NAL header from the FU indicator and the FU header
          will_store_next = fits_ok;
          if (in_byte[7]) begin
            op.sc  = fits_ok;
            op.val = {nal_header[7:5], in_byte[4:0]};
          end
        end else if (will_store &&
                     ((payload_kind == PK_SINGLE && byte_index >= IDX_FU_HDR) ||
                      (payload_kind == PK_FUA && byte_index > IDX_FU_HDR))) begin
          op.dat = 1'b1;
          op.val = in_byte;
        end

        if (op.sc) begin
          fill_mid = frame_fill + FILL_W'(START_CODE_LEN);
        end else if (op.dat) begin
          fill_mid = frame_fill + FILL_W'(1);
        end
        frame_fill_next = fill_mid;
        byte_index_next = idx_inc;

        if (idx_inc >= packet_length) begin
          pkt_ok = !(payload_kind_next == PK_FUA && packet_length < MIN_FUA_PKT_LEN);
          if (marker_flag_next && pkt_ok) begin
            op.fin          = (fill_mid != '0);
            op.count        = fill_mid;
            frame_fill_next = '0;
          end
          phase_next = PH_HUNT;
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      channel_id    <= '0;
      packet_length <= '0;
      byte_index    <= '0;
      marker_flag   <= 1'b0;
      nal_header    <= '0;
      payload_kind  <= PK_NONE;
      will_store    <= 1'b0;
      frame_fill    <= '0;
    end else if (take) begin
      phase         <= phase_next;
      channel_id    <= channel_id_next;
      packet_length <= packet_length_next;
      byte_index    <= byte_index_next;
      marker_flag   <= marker_flag_next;
      nal_header    <= nal_header_next;
      payload_kind  <= payload_kind_next;
      will_store    <= will_store_next;
      frame_fill    <= frame_fill_next;
    end
  end

  assign push    = take && (op.sc || op.dat || op.fin);
  assign push_op = op;

endmodule

>>> src/rhd_fifo.sv
// Short operation queue between the parser and the result sequencer.
// Depends on rhd_pkg for op_t and the depth.
`timescale 1ns / 1ps

module rhd_fifo
  import rhd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  input  logic pop,
  output op_t  head_op,
  output logic head_valid,
  output logic full
);

  op_t                   entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      priority if (push && !pop) begin
        count <= count + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - FIFO_CNT_W'(1);
      end
    end
  end

  assign head_op    = entries[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == FIFO_CNT_W'(FIFO_DEPTH));

endmodule

>>> src/rhd_back.sv
// Back end of the RTP H.264 depacketizer: expands each queued operation into
// its result items, one per cycle while the receiver is ready, through a
// registered output stage. Depends on rhd_pkg.
`timescale 1ns / 1ps

module rhd_back
  import rhd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  op_t                 head_op,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,
  output logic                m_tuser,
  output logic                m_tlast
);

  logic [2:0]        pos;
  logic [2:0]        data_cnt;
  logic [2:0]        total;
  logic              is_data;
  logic              res_last;
  logic [7:0]        res_byte;
  logic [FILL_W-1:0] res_count;
  logic              load;

  assign data_cnt = head_op.sc ? START_CODE_LEN : {2'b00, head_op.dat};
  assign total    = data_cnt + {2'b00, head_op.fin};
  assign is_data  = (pos < data_cnt);
  assign res_last = (pos == total - 3'd1);

  always_comb begin
    res_byte  = '0;
    res_count = '0;
    if (is_data) begin
      if (head_op.sc) begin
        if (pos == SC_ONE_POS) begin
          res_byte = 8'h01;
        end else if (pos == SC_HDR_POS) begin
          res_byte = head_op.val;
        end
      end else begin
        res_byte = head_op.val;
      end
    end else begin
      res_count = head_op.count;
    end
  end

  assign load = head_valid && (!m_tvalid || m_tready);
  assign pop  = load && res_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      pos      <= '0;
    end else begin
      if (!m_tvalid || m_tready) begin
        m_tvalid <= head_valid;
      end
      if (load) begin
        pos <= res_last ? 3'd0 : pos + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {(M_DATA_W - FILL_W - 8)'(0), res_count, res_byte};
      m_tuser <= !is_data;
      m_tlast <= res_last;
    end
  end

endmodule

>>> src/rtp_h264_depacketizer.sv
// RTP H.264 depacketizer for an RTSP TCP-interleaved byte stream. The block
// takes one stream byte per transaction on the slave side, hunts for the '$'
// mark, reads the channel byte and the big-endian 16-bit length, and treats
// packets on the configured video channel as RTP with a fixed 12-byte header.
// Packets on other channels, longer than max_packet_len or shorter than 13
// bytes are consumed silently. Single NAL units (types 1 to 23) leave in
// Annex-B form behind a 00 00 00 01 start code; FU-A fragments are rebuilt
// into one NAL unit, the start fragment giving the start code and the
// reconstructed NAL header. A packet is kept only if the frame fill plus its
// Annex-B size stays strictly below frame_capacity (clamped to 1 MiB). On a
// packet carrying the RTP marker bit, a frame-end result (tuser high) reports
// the stored byte count if it is not zero, and the fill restarts at zero.
// Each result is one master-side transaction; tlast marks the final result
// of one input byte. Rate: one input byte is accepted per cycle while the
// four-entry operation queue has room, and one result leaves per cycle while
// the receiver is ready; a byte that opens a NAL unit yields up to six
// results, the queue absorbing such bursts. Configuration writes take effect
// at the next edge and are meant for idle periods only. There is no clearing
// pass after reset.
`timescale 1ns / 1ps

module rtp_h264_depacketizer
  import rhd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Stream input
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] in_byte
  // Result output
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_DATA_W-1:0]   m_tdata,   // [7:0] data_byte, [27:8] frame_bytes, [31:28] 0
  output logic                  m_tuser,   // [0] kind: 0 data byte, 1 frame end
  output logic                  m_tlast
);

  logic take;
  logic push;
  op_t  push_op;
  logic pop;
  op_t  head_op;
  logic head_valid;
  logic full;

  // Accept a byte whenever the queue can take whatever it may produce
  assign s_tready = !full;
  assign take     = s_tvalid && s_tready;

  // Parse and classify each byte; keep the frame fill here so the fit
  // decision never waits on the output side
  rhd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .in_byte   (s_tdata),
    .push      (push),
    .push_op   (push_op)
  );

  // Decouple parser and sequencer
  rhd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .pop        (pop),
    .head_op    (head_op),
    .head_valid (head_valid),
    .full       (full)
  );

  // Expand each operation into start code, payload and frame-end results
  rhd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

>>> src/rhd_checker.sv
// Port-level checker of the RTP H.264 depacketizer, bound to the top level.
// Depends on rhd_pkg and the assertion macros in the defines header.
`timescale 1ns / 1ps
`include "rtp_h264_depacketizer_defines.svh"

module rhd_checker
  import rhd_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [M_DATA_W-1:0]   m_tdata,
  input logic                  m_tuser,
  input logic                  m_tlast
);

  logic [7:0]        res_byte;
  logic [FILL_W-1:0] res_count;

  assign res_byte  = m_tdata[7:0];
  assign res_count = m_tdata[FILL_W+7:8];

  // A stalled result holds
  `RHD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // A frame end carries a non-zero count, no data byte, and closes its byte
  `RHD_ASSERT_NOW(a_fin_shape, m_tvalid && m_tuser, res_byte == 8'd0 && res_count != '0 && m_tlast)

  // A data byte carries no count and no stray upper bits
  `RHD_ASSERT_NOW(a_data_shape, m_tvalid && !m_tuser, m_tdata[31:8] == 24'd0)

  // Results of one input byte leave without gaps
  `RHD_ASSERT_NEXT(a_burst_gapless, m_tvalid && m_tready && !m_tlast, m_tvalid)

endmodule

bind rtp_h264_depacketizer rhd_checker u_rhd_checker (.*);

>>> sim/rtp_h264_depacketizer_checker.sv
// Checker for the RTP H.264 depacketizer: watches the register port and both
// stream channels, predicts the Annex-B results and compares them in order.
// Depends on rhd_pkg for the register indexes, framing constants and reset values.
`timescale 1ns / 1ps

module rtp_h264_depacketizer_checker
  import rhd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] in_byte
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [M_DATA_W-1:0]   m_tdata,   // [7:0] data_byte, [27:8] frame_bytes
  input  logic                  m_tuser,   // [0] kind
  input  logic                  m_tlast,
  output int                    fail_count,
  output int                    pending
);

  localparam logic KIND_DATA      = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;
  localparam int   MAX_RESULTS    = 6;

  typedef enum logic [2:0] {
    SEEK_DOLLAR, READ_CHANNEL, READ_LEN_HI, READ_LEN_LO, IN_PAYLOAD, SKIP_PACKET
  } stream_phase_t;

  typedef enum logic [1:0] {PAY_NONE, PAY_SINGLE, PAY_FRAG} payload_t;

  typedef struct {
    logic        kind;
    logic [7:0]  data_byte;
    logic [19:0] frame_bytes;
    logic        last;
  } annexb_result_t;

  // Register copies
  logic [20:0] capacity;
  logic [7:0]  video_chan;
  logic [15:0] max_len;

  // Parser state
  stream_phase_t phase;
  payload_t      payload;
  logic [7:0]    chan_id;
  logic [15:0]   pkt_len;
  logic [15:0]   pos;
  logic          marker;
  logic [7:0]    nal_hdr;
  logic          storing;
  logic [19:0]   fill;

  annexb_result_t annexb_expected[$];
  annexb_result_t step_buf[MAX_RESULTS];
  int             n_out;

  function automatic bit fits(input int unsigned extra);
    int unsigned cap_eff;
    cap_eff = (capacity > CAP_LIMIT) ? int'(CAP_LIMIT) : int'(capacity);
    return (int'(fill) + extra) < cap_eff;
  endfunction

  task automatic emit(input logic kind, input logic [7:0] data, input logic [19:0] count);
    if (n_out < MAX_RESULTS) begin
      step_buf[n_out] = '{kind, data, count, 1'b0};
      n_out++;
    end
  endtask

  task automatic emit_byte(input logic [7:0] data);
    emit(KIND_DATA, data, 20'd0);
    fill = fill + 20'd1;
  endtask

  task automatic emit_start_code(input logic [7:0] header);
    emit_byte(8'h00);
    emit_byte(8'h00);
    emit_byte(8'h00);
    emit_byte(8'h01);
    emit_byte(header);
  endtask

  // Advance the parser by one stream byte and queue what it produces.
  task automatic depacketize(input logic [7:0] b);
    int unsigned nal_len;
    logic        frag_ok;
    n_out = 0;
    case (phase)
      SEEK_DOLLAR: begin
        if (b == DOLLAR) phase = READ_CHANNEL;
      end
      READ_CHANNEL: begin
        chan_id = b;
        phase = READ_LEN_HI;
      end
      READ_LEN_HI: begin
        pkt_len = {b, 8'h00};
        phase = READ_LEN_LO;
      end
      READ_LEN_LO: begin
        pkt_len = {pkt_len[15:8], b};
        pos = '0;
        marker = 1'b0;
        payload = PAY_NONE;
        storing = 1'b0;
        if (pkt_len == 16'd0) phase = SEEK_DOLLAR;
        else if (pkt_len > max_len || chan_id != video_chan || pkt_len < MIN_PKT_LEN)
          phase = SKIP_PACKET;
        else phase = IN_PAYLOAD;
      end
      SKIP_PACKET: begin
        pos = pos + 16'd1;
        if (pos >= pkt_len) phase = SEEK_DOLLAR;
      end
      default: begin
        nal_len = int'(pkt_len) - int'(RTP_HDR_LEN);
        if (pos == IDX_MARKER) marker = b[7];
        if (pos == IDX_NAL_HDR) begin
          nal_hdr = b;
          if (b[4:0] >= NAL_SINGLE_MIN && b[4:0] <= NAL_SINGLE_MAX) begin
            payload = PAY_SINGLE;
            storing = fits(nal_len + 4);
            if (storing) emit_start_code(b);
          end else if (b[4:0] == NAL_FU_A) begin
            payload = PAY_FRAG;
            storing = 1'b0;
          end else begin
            payload = PAY_NONE;
            storing = 1'b0;
          end
        end else if (pos == IDX_FU_HDR && payload == PAY_FRAG) begin
          if (b[7]) begin
            storing = fits(nal_len + 3);
            if (storing) emit_start_code({nal_hdr[7:5], b[4:0]});
          end else begin
            storing = fits(nal_len - 2);
          end
        end else if (storing && ((payload == PAY_SINGLE && pos > IDX_NAL_HDR) ||
                                 (payload == PAY_FRAG && pos > IDX_FU_HDR))) begin
          emit_byte(b);
        end
        pos = pos + 16'd1;
        if (pos >= pkt_len) begin
          // a fragment packet without its FU header does not end the frame
          frag_ok = !(payload == PAY_FRAG && pkt_len < MIN_FUA_PKT_LEN);
          if (marker && frag_ok) begin
            if (fill > 0) emit(KIND_FRAME_END, 8'h00, fill);
            fill = '0;
          end
          phase = SEEK_DOLLAR;
        end
      end
    endcase
    if (n_out > 0) step_buf[n_out-1].last = 1'b1;
    for (int i = 0; i < n_out; i++) annexb_expected.push_back(step_buf[i]);
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    annexb_result_t want;
    if (rst) begin
      capacity   = RST_FRAME_CAPACITY;
      video_chan = RST_VIDEO_CHANNEL;
      max_len    = RST_MAX_PKT_LEN;
      phase      = SEEK_DOLLAR;
      payload    = PAY_NONE;
      chan_id    = '0;
      pkt_len    = '0;
      pos        = '0;
      marker     = 1'b0;
      nal_hdr    = '0;
      storing    = 1'b0;
      fill       = '0;
      annexb_expected.delete();
      fail_count = 0;
      pending    = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_FRAME_CAPACITY: capacity   = cfg_wdata[20:0];
          CFG_VIDEO_CHANNEL:  video_chan = cfg_wdata[7:0];
          CFG_MAX_PKT_LEN:    max_len    = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) depacketize(s_tdata);
      if (m_tvalid && m_tready) begin
        if (annexb_expected.size() == 0) begin
          $error("result with no expectation waiting: tuser %0b tdata 0x%08h tlast %0b",
                 m_tuser, m_tdata, m_tlast);
          fail_count++;
        end else begin
          want = annexb_expected.pop_front();
          check_field("kind", want.kind, m_tuser);
          check_field("data_byte", want.data_byte, m_tdata[7:0]);
          check_field("frame_bytes", want.frame_bytes, m_tdata[27:8]);
          check_field("last", want.last, m_tlast);
        end
      end
      pending = annexb_expected.size();
    end
  end

endmodule

>>> sim/rtp_h264_depacketizer_test.sv
// Top of the RTP H.264 depacketizer testbench: clock, reset, register writes,
// interleaved stream stimulus, result back-pressure and the verdict.
// Depends on rhd_pkg, rtp_h264_depacketizer and rtp_h264_depacketizer_checker.
`timescale 1ns / 1ps

module rtp_h264_depacketizer_test;
  import rhd_pkg::*;

  // Long receiver hold-off used to fill the block's operation queue
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  // Cycles to let in-flight bytes that cause no result work their way through
  localparam int unsigned SETTLE_CYCLES   = 8;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata   = '0;   // [7:0] in_byte
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;          // [7:0] data_byte, [27:8] frame_bytes
  logic                  m_tuser;          // [0] kind
  logic                  m_tlast;

  int          fail_count;
  int          pending;
  bit          hold_request = 1'b0;
  int unsigned send_calm    = 0;   // transactions left to offer back to back
  int unsigned body_bytes   = 0;   // packet body bytes sent in the current phase
  logic [7:0]  cur_chan;
  logic [15:0] cur_max;

  rtp_h264_depacketizer i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  rtp_h264_depacketizer_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin : clock_gen
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs: far beyond the slowest legal run.
  initial begin : watchdog
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Mostly short idles, now and then a long one.
  function automatic int unsigned idle_gap();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  // Result side: random idles and calm stretches, plus the long hold-off on
  // request. Exactly one update of m_tready per falling edge.
  initial begin : result_sink
    int unsigned idle_left;
    int unsigned calm_left;
    int unsigned hold_left;
    idle_left = 0;
    calm_left = 0;
    hold_left = 0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_OFF_CYCLES - 1;
        m_tready <= 1'b0;
      end else if (idle_left > 0) begin
        m_tready <= 1'b0;
        idle_left--;
      end else begin
        m_tready <= 1'b1;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 99) < 5) calm_left = $urandom_range(20, 150);
        else if ($urandom_range(0, 99) < 25) idle_left = idle_gap();
      end
    end
  end

  // Offer one stream byte and hold it until the transaction completes. Entered
  // and left at a falling edge.
  task automatic send_byte(input logic [7:0] value);
    int unsigned gap;
    gap = 0;
    if (send_calm > 0) send_calm--;
    else if ($urandom_range(0, 99) < 4) send_calm = $urandom_range(20, 120);
    else if ($urandom_range(0, 99) < 20) gap = idle_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // One interleaved frame: '$', channel, big-endian length, then the body with
  // the RTP marker in byte 1, the NAL header in byte 12 and the FU header in
  // byte 13. Everything else in the body is random.
  task automatic send_rtp(input logic [7:0] chan, input logic [15:0] len,
                          input logic mark, input logic [7:0] nal, input logic [7:0] fu);
    logic [7:0] b;
    send_byte(DOLLAR);
    send_byte(chan);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    for (int i = 0; i < int'(len); i++) begin
      b = 8'($urandom_range(0, 255));
      if (i == int'(IDX_MARKER)) b[7] = mark;
      else if (i == int'(IDX_NAL_HDR)) b = nal;
      else if (i == int'(IDX_FU_HDR)) b = fu;
      send_byte(b);
    end
    body_bytes += len;
  endtask

  // Stop offering and wait until every predicted result has been taken.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input int unsigned cap, input logic [7:0] chan,
                           input logic [15:0] maxlen);
    write_reg(CFG_FRAME_CAPACITY, cap);
    write_reg(CFG_VIDEO_CHANNEL, chan);
    write_reg(CFG_MAX_PKT_LEN, maxlen);
    cur_chan = chan;
    cur_max  = maxlen;
    body_bytes = 0;
  endtask

  // Mostly short bodies, occasionally a longer one, kept within the length limit.
  function automatic logic [15:0] pick_len();
    int unsigned len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 100) : $urandom_range(13, 30);
    if (len > cur_max && cur_max >= MIN_PKT_LEN) len = cur_max;
    return 16'(len);
  endfunction

  function automatic logic [7:0] random_nal(input logic [4:0] unit_type);
    return {3'($urandom_range(0, 7)), unit_type};
  endfunction

  // One burst of traffic: well-formed frames most of the time, the rest noise,
  // foreign channels, odd NAL types and malformed lengths.
  task automatic send_random_traffic();
    int unsigned  r;
    int unsigned  count;
    logic [4:0]   orig;
    logic [7:0]   nal;
    logic [4:0]   odd_types[8];
    logic [7:0]   b;
    odd_types = '{5'd0, 5'd24, 5'd25, 5'd26, 5'd27, 5'd29, 5'd30, 5'd31};
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 4)) begin
        b = 8'($urandom_range(0, 255));
        if (b == DOLLAR) b = 8'hA5;
        send_byte(b);
      end
    end
    r = $urandom_range(0, 99);
    if (r < 45) begin
      // single NAL units, marker on the last one
      count = $urandom_range(1, 3);
      for (int i = 0; i < int'(count); i++)
        send_rtp(cur_chan, pick_len(), i == int'(count) - 1,
                 random_nal(5'($urandom_range(NAL_SINGLE_MIN, NAL_SINGLE_MAX))),
                 8'($urandom_range(0, 255)));
    end else if (r < 80) begin
      // fragmented unit: start, up to two middles, end with marker
      nal  = random_nal(NAL_FU_A);
      orig = 5'($urandom_range(0, 31));
      send_rtp(cur_chan, pick_len(), 1'b0, nal, {2'b10, 1'($urandom_range(0, 1)), orig});
      repeat ($urandom_range(0, 2))
        send_rtp(cur_chan, pick_len(), 1'b0, nal, {2'b00, 1'($urandom_range(0, 1)), orig});
      send_rtp(cur_chan, pick_len(), 1'b1, nal, {2'b01, 1'($urandom_range(0, 1)), orig});
    end else if (r < 86) begin
      send_rtp(cur_chan, pick_len(), 1'($urandom_range(0, 1)),
               random_nal(odd_types[$urandom_range(0, 7)]), 8'($urandom_range(0, 255)));
    end else if (r < 91) begin
      send_rtp(cur_chan ^ 8'($urandom_range(1, 255)), pick_len(), 1'($urandom_range(0, 1)),
               random_nal(5'($urandom_range(1, 23))), 8'($urandom_range(0, 255)));
    end else if (r < 95 && cur_max <= 200) begin
      send_rtp(cur_chan, cur_max + 16'($urandom_range(1, 16)), 1'b1,
               random_nal(5'($urandom_range(1, 23))), 8'($urandom_range(0, 255)));
    end else if ($urandom_range(0, 1) == 0) begin
      send_rtp(cur_chan, 16'($urandom_range(0, 12)), 1'($urandom_range(0, 1)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end else begin
      // fragment too short to carry an FU header
      send_rtp(cur_chan, MIN_PKT_LEN, 1'($urandom_range(0, 1)), random_nal(NAL_FU_A), 8'h00);
    end
  endtask

  task automatic random_phase(input int unsigned budget);
    while (body_bytes < budget) send_random_traffic();
    settle();
  endtask

  initial begin : stimulus
    // Hold reset, then release it at a falling edge.
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed part: minimum capacity and a small length limit make every
    // corner cheap.
    configure(16, 8'd5, 16'd24);
    send_byte(8'h00);                                 // noise while hunting
    send_byte(8'hFF);
    send_byte(8'h23);
    send_byte(8'h25);
    send_rtp(8'd5, 16'd0, 1'b0, 8'h00, 8'h00);        // zero length
    send_rtp(8'd5, 16'd13, 1'b0, 8'h01, 8'h00);       // type 1, header only
    send_rtp(8'd5, 16'd14, 1'b1, 8'h77, 8'h00);       // type 23, frame end
    send_rtp(8'd5, 16'd13, 1'b1, 8'h00, 8'h00);       // marker on empty frame
    send_rtp(8'd5, 16'd14, 1'b0, 8'hE5, 8'h00);       // forbidden bit set, type 5
    send_rtp(8'd5, 16'd13, 1'b1, 8'h18, 8'h00);       // type 24 still ends the frame
    send_rtp(8'd6, 16'd13, 1'b1, 8'h05, 8'h00);       // foreign channel
    send_rtp(8'd5, 16'd25, 1'b1, 8'h05, 8'h00);       // one byte over the limit
    send_rtp(8'd5, 16'd12, 1'b1, 8'h05, 8'h00);       // shorter than a minimal packet
    send_rtp(8'd5, 16'd1, 1'b1, 8'h05, 8'h00);
    send_rtp(8'd5, 16'd16, 1'b0, 8'h7C, 8'h85);       // fragment start, rebuilt header
    send_rtp(8'd5, 16'd15, 1'b0, 8'h7C, 8'h05);       // fragment middle
    send_rtp(8'd5, 16'd13, 1'b1, 8'h7C, 8'h00);       // fragment with no FU header
    send_rtp(8'd5, 16'd14, 1'b1, 8'h7C, 8'h45);       // empty fragment end, frame end
    send_rtp(8'd5, 16'd14, 1'b0, 8'h1C, 8'h9F);       // empty fragment start
    send_rtp(8'd5, 16'd20, 1'b1, 8'h41, 8'h00);       // does not fit, marker applies
    send_rtp(8'd5, 16'd24, 1'b0, 8'h41, 8'h00);       // fill plus bytes equals capacity
    send_rtp(8'd5, 16'd23, 1'b1, 8'h41, 8'h00);       // one below capacity
    send_rtp(8'd5, 16'd13, 1'b1, 8'h61, 8'h00);       // six results from one byte
    settle();

    // Minimum capacity, top channel: most packets are dropped for room.
    configure(16, 8'd255, 16'd40);
    random_phase(20);

    // Capacity above the clamp and the widest length limit.
    configure(21'h1F_FFFF, 8'd0, 16'hFFFF);
    random_phase(20);

    // Maximum capacity; hold the result side off for a long stretch while the
    // stream keeps coming, so the operation queue fills and input stalls.
    configure(1048576, 8'($urandom_range(0, 255)), 16'd1500);
    hold_request = 1'b1;
    send_rtp(cur_chan, 16'd30, 1'b1, 8'h65, 8'h00);
    random_phase(40);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
